>>> rtl/core/lsp_pkg.sv
// ----------------------------------------------------------------------------
// Spot line field parser package
// Shared constants, state types and the status record of the line scanner.
// ----------------------------------------------------------------------------
package lsp_pkg;

    localparam int LINE_BYTES_DEF    = 512;
    localparam int SPOTTER_BYTES_DEF = 16;
    localparam int FREQ_BYTES_DEF    = 16;
    localparam int CALL_BYTES_DEF    = 16;
    localparam int COMMENT_BYTES_DEF = 64;

    localparam int MAX_RESULTS = 16;
    localparam int NUM_FIELDS  = 5;
    localparam int PREFIX_LEN  = 6;
    localparam int TIME_LEN    = 5;
    localparam int CHUNK_BYTES = 8;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_Z     = 8'h5A;

    // First character in the most significant byte.
    localparam logic [8*PREFIX_LEN-1:0] PREFIX_STR = "DX de ";

    localparam logic [2:0] FID_SPOTTER = 3'd0;
    localparam logic [2:0] FID_FREQ    = 3'd1;
    localparam logic [2:0] FID_CALL    = 3'd2;
    localparam logic [2:0] FID_COMMENT = 3'd3;
    localparam logic [2:0] FID_TIME    = 3'd4;

    typedef enum logic [1:0] {
        TP_COLLECT,
        TP_SCAN,
        TP_EMIT
    } top_state_t;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_CRWAIT,
        SC_FWD,
        SC_FIN,
        SC_CALC,
        SC_BREQ,
        SC_BWAIT,
        SC_DONE
    } scan_state_t;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_G1,
        PH_T1,
        PH_G2,
        PH_T2,
        PH_G3,
        PH_REST
    } scan_phase_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SETUP,
        EM_READ,
        EM_PUT
    } emit_state_t;

    typedef struct packed {
        logic done;
        logic spot;
    } scan_stat_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] i);
        logic [7:0] c;
        c = CH_NUL;
        case (i)
            3'd0:    c = PREFIX_STR[47:40];
            3'd1:    c = PREFIX_STR[39:32];
            3'd2:    c = PREFIX_STR[31:24];
            3'd3:    c = PREFIX_STR[23:16];
            3'd4:    c = PREFIX_STR[15:8];
            3'd5:    c = PREFIX_STR[7:0];
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic is_gap(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_trim(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_NL);
    endfunction

endpackage

>>> rtl/core/lsp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/lsp_scan.sv
// ----------------------------------------------------------------------------
// Line scanner
// Walks a stored line once and works out the start and length of each field.
// ----------------------------------------------------------------------------
module lsp_scan #(
    parameter int LINE_BYTES    = lsp_pkg::LINE_BYTES_DEF,
    parameter int SPOTTER_BYTES = lsp_pkg::SPOTTER_BYTES_DEF,
    parameter int FREQ_BYTES    = lsp_pkg::FREQ_BYTES_DEF,
    parameter int CALL_BYTES    = lsp_pkg::CALL_BYTES_DEF,
    parameter int COMMENT_BYTES = lsp_pkg::COMMENT_BYTES_DEF,
    localparam int AW           = $clog2(LINE_BYTES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [AW-1:0]       len,
    output logic [AW-1:0]       raddr,
    input  logic [7:0]          rdata,
    output lsp_pkg::scan_stat_t stat,
    output logic [AW-1:0]       fs [lsp_pkg::NUM_FIELDS],
    output logic [AW-1:0]       fl [lsp_pkg::NUM_FIELDS]
);

    lsp_pkg::scan_state_t state_reg, state_next;
    lsp_pkg::scan_phase_t phase_reg, phase_next;
    logic [AW-1:0] len_reg, len_next;
    logic [AW-1:0] iss_reg, iss_next;
    logic [AW-1:0] ridx_reg, ridx_next;
    logic          rv_reg, rv_next;
    logic [AW-1:0] end_reg, end_next;
    logic          bad_reg, bad_next;
    logic          spot_reg, spot_next;
    logic [AW-1:0] colon_reg, colon_next;
    logic [AW-1:0] frs_reg, frs_next, fre_reg, fre_next;
    logic [AW-1:0] cas_reg, cas_next, cae_reg, cae_next;
    logic [AW-1:0] p_reg, p_next;
    logic [AW-1:0] lk_reg, lk_next;
    logic          lz_reg, lz_next;
    logic [AW-1:0] rest_reg, rest_next;
    logic          tm_reg, tm_next;
    logic [AW-1:0] bpos_reg, bpos_next;
    logic [AW-1:0] clen_reg, clen_next;

    function automatic logic [AW-1:0] clip(input logic [AW-1:0] n, input int size);
        return (int'(n) >= size) ? AW'(size - 1) : n;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsp_pkg::SC_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        len_reg   <= len_next;
        iss_reg   <= iss_next;
        ridx_reg  <= ridx_next;
        end_reg   <= end_next;
        bad_reg   <= bad_next;
        spot_reg  <= spot_next;
        colon_reg <= colon_next;
        frs_reg   <= frs_next;
        fre_reg   <= fre_next;
        cas_reg   <= cas_next;
        cae_reg   <= cae_next;
        p_reg     <= p_next;
        lk_reg    <= lk_next;
        lz_reg    <= lz_next;
        rest_reg  <= rest_next;
        tm_reg    <= tm_next;
        bpos_reg  <= bpos_next;
        clen_reg  <= clen_next;
    end

    always_comb
    begin
        logic [AW-1:0] rest_c;
        state_next = state_reg;
        phase_next = phase_reg;
        len_next   = len_reg;
        iss_next   = iss_reg;
        ridx_next  = ridx_reg;
        rv_next    = 1'b0;
        end_next   = end_reg;
        bad_next   = bad_reg;
        spot_next  = spot_reg;
        colon_next = colon_reg;
        frs_next   = frs_reg;
        fre_next   = fre_reg;
        cas_next   = cas_reg;
        cae_next   = cae_reg;
        p_next     = p_reg;
        lk_next    = lk_reg;
        lz_next    = lz_reg;
        rest_next  = rest_reg;
        tm_next    = tm_reg;
        bpos_next  = bpos_reg;
        clen_next  = clen_reg;
        raddr      = len - AW'(1);
        stat       = '0;
        rest_c     = '0;

        case (state_reg)
            lsp_pkg::SC_IDLE:
            begin
                if (start)
                begin
                    len_next   = len;
                    phase_next = lsp_pkg::PH_HEAD;
                    bad_next   = 1'b0;
                    iss_next   = '0;
                    if (len == '0)
                    begin
                        end_next   = '0;
                        state_next = lsp_pkg::SC_FIN;
                    end
                    else
                    begin
                        state_next = lsp_pkg::SC_CRWAIT;
                    end
                end
            end

            lsp_pkg::SC_CRWAIT:
            begin
                // Read data holds the last stored byte of the line.
                if (rdata == lsp_pkg::CH_CR)
                begin
                    len_next = len_reg - AW'(1);
                end
                state_next = lsp_pkg::SC_FWD;
            end

            lsp_pkg::SC_FWD:
            begin
                if (iss_reg < len_reg)
                begin
                    raddr     = iss_reg;
                    rv_next   = 1'b1;
                    ridx_next = iss_reg;
                    iss_next  = iss_reg + AW'(1);
                end
                if (rv_reg)
                begin
                    if (rdata == lsp_pkg::CH_NUL)
                    begin
                        end_next   = ridx_reg;
                        rv_next    = 1'b0;
                        state_next = lsp_pkg::SC_FIN;
                    end
                    else
                    begin
                        if (int'(ridx_reg) < lsp_pkg::PREFIX_LEN &&
                            rdata != lsp_pkg::prefix_char(ridx_reg[2:0]))
                        begin
                            bad_next = 1'b1;
                        end
                        case (phase_reg)
                            lsp_pkg::PH_HEAD:
                            begin
                                if (int'(ridx_reg) >= lsp_pkg::PREFIX_LEN &&
                                    rdata == lsp_pkg::CH_COLON)
                                begin
                                    colon_next = ridx_reg;
                                    phase_next = lsp_pkg::PH_G1;
                                end
                            end
                            lsp_pkg::PH_G1:
                            begin
                                if (!lsp_pkg::is_gap(rdata))
                                begin
                                    frs_next   = ridx_reg;
                                    phase_next = lsp_pkg::PH_T1;
                                end
                            end
                            lsp_pkg::PH_T1:
                            begin
                                if (lsp_pkg::is_gap(rdata))
                                begin
                                    fre_next   = ridx_reg;
                                    phase_next = lsp_pkg::PH_G2;
                                end
                            end
                            lsp_pkg::PH_G2:
                            begin
                                if (!lsp_pkg::is_gap(rdata))
                                begin
                                    cas_next   = ridx_reg;
                                    phase_next = lsp_pkg::PH_T2;
                                end
                            end
                            lsp_pkg::PH_T2:
                            begin
                                if (lsp_pkg::is_gap(rdata))
                                begin
                                    cae_next   = ridx_reg;
                                    phase_next = lsp_pkg::PH_G3;
                                end
                            end
                            lsp_pkg::PH_G3:
                            begin
                                if (!lsp_pkg::is_gap(rdata))
                                begin
                                    p_next     = ridx_reg;
                                    lk_next    = lsp_pkg::is_trim(rdata) ? ridx_reg
                                                                          : ridx_reg + AW'(1);
                                    lz_next    = (rdata == lsp_pkg::CH_Z);
                                    phase_next = lsp_pkg::PH_REST;
                                end
                            end
                            lsp_pkg::PH_REST:
                            begin
                                if (!lsp_pkg::is_trim(rdata))
                                begin
                                    lk_next = ridx_reg + AW'(1);
                                    lz_next = (rdata == lsp_pkg::CH_Z);
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
                else if (iss_reg >= len_reg)
                begin
                    end_next   = len_reg;
                    state_next = lsp_pkg::SC_FIN;
                end
            end

            lsp_pkg::SC_FIN:
            begin
                spot_next = (int'(end_reg) >= lsp_pkg::PREFIX_LEN) && !bad_reg &&
                            (phase_reg != lsp_pkg::PH_HEAD);
                // Positions not reached before the end fall on the end.
                if (phase_reg == lsp_pkg::PH_G1)
                begin
                    frs_next = end_reg;
                end
                if (phase_reg == lsp_pkg::PH_G1 || phase_reg == lsp_pkg::PH_T1)
                begin
                    fre_next = end_reg;
                end
                if (phase_reg == lsp_pkg::PH_G1 || phase_reg == lsp_pkg::PH_T1 ||
                    phase_reg == lsp_pkg::PH_G2)
                begin
                    cas_next = end_reg;
                end
                if (phase_reg != lsp_pkg::PH_G3 && phase_reg != lsp_pkg::PH_REST)
                begin
                    cae_next = end_reg;
                end
                if (phase_reg != lsp_pkg::PH_REST)
                begin
                    p_next = end_reg;
                end
                state_next = spot_next ? lsp_pkg::SC_CALC : lsp_pkg::SC_DONE;
            end

            lsp_pkg::SC_CALC:
            begin
                rest_c    = (phase_reg == lsp_pkg::PH_REST) ? lk_reg - p_reg : '0;
                rest_next = rest_c;
                if (phase_reg == lsp_pkg::PH_REST && lz_reg &&
                    int'(rest_c) >= lsp_pkg::TIME_LEN)
                begin
                    tm_next    = 1'b1;
                    bpos_next  = lk_reg - AW'(lsp_pkg::TIME_LEN);
                    state_next = lsp_pkg::SC_BREQ;
                end
                else
                begin
                    tm_next    = 1'b0;
                    clen_next  = rest_c;
                    state_next = lsp_pkg::SC_DONE;
                end
            end

            lsp_pkg::SC_BREQ:
            begin
                if (bpos_reg == p_reg)
                begin
                    clen_next  = '0;
                    state_next = lsp_pkg::SC_DONE;
                end
                else
                begin
                    raddr      = bpos_reg - AW'(1);
                    state_next = lsp_pkg::SC_BWAIT;
                end
            end

            lsp_pkg::SC_BWAIT:
            begin
                if (lsp_pkg::is_gap(rdata))
                begin
                    bpos_next  = bpos_reg - AW'(1);
                    state_next = lsp_pkg::SC_BREQ;
                end
                else
                begin
                    clen_next  = bpos_reg - p_reg;
                    state_next = lsp_pkg::SC_DONE;
                end
            end

            lsp_pkg::SC_DONE:
            begin
                stat.done  = 1'b1;
                stat.spot  = spot_reg;
                state_next = lsp_pkg::SC_IDLE;
            end

            default:
            begin
                state_next = lsp_pkg::SC_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fs[0] = AW'(lsp_pkg::PREFIX_LEN);
        fl[0] = clip(colon_reg - AW'(lsp_pkg::PREFIX_LEN), SPOTTER_BYTES);
        fs[1] = frs_reg;
        fl[1] = clip(fre_reg - frs_reg, FREQ_BYTES);
        fs[2] = cas_reg;
        fl[2] = clip(cae_reg - cas_reg, CALL_BYTES);
        fs[3] = p_reg;
        fl[3] = clip(clen_reg, COMMENT_BYTES);
        fs[4] = tm_reg ? p_reg + rest_reg - AW'(lsp_pkg::TIME_LEN) : p_reg + rest_reg;
        fl[4] = tm_reg ? AW'(lsp_pkg::TIME_LEN) : '0;
    end

endmodule

>>> rtl/core/lsp_emit.sv
// ----------------------------------------------------------------------------
// Chunk emitter
// Reads each field back from the line store and sends it in chunks of up to eight bytes.
// ----------------------------------------------------------------------------
module lsp_emit #(
    parameter int LINE_BYTES = lsp_pkg::LINE_BYTES_DEF,
    localparam int AW        = $clog2(LINE_BYTES),
    localparam int CW        = $clog2(lsp_pkg::MAX_RESULTS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [AW-1:0] fs [lsp_pkg::NUM_FIELDS],
    input  logic [AW-1:0] fl [lsp_pkg::NUM_FIELDS],
    output logic [AW-1:0] raddr,
    input  logic [7:0]    rdata,
    output logic          done,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    field_id,
    output logic [63:0]   chunk_bytes,
    output logic [3:0]    chunk_len,
    output logic          last_of_spot
);

    lsp_pkg::emit_state_t state_reg, state_next;
    logic [AW-1:0] fs_reg [lsp_pkg::NUM_FIELDS];
    logic [AW-1:0] fl_reg [lsp_pkg::NUM_FIELDS];
    logic          load;
    logic [2:0]    fld_reg, fld_next;
    logic [AW-1:0] off_reg, off_next;
    logic [AW-1:0] base_reg, base_next;
    logic [3:0]    k_reg, k_next;
    logic [3:0]    iss_reg, iss_next;
    logic          rv_reg, rv_next;
    logic [2:0]    lane_reg, lane_next;
    logic [63:0]   acc_reg, acc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ov_reg, ov_next;
    logic [2:0]    fid_reg, fid_next;
    logic [63:0]   ob_reg, ob_next;
    logic [3:0]    ol_reg, ol_next;
    logic          olast_reg, olast_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsp_pkg::EM_IDLE;
            rv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fs_reg <= fs;
            fl_reg <= fl;
        end
        fld_reg   <= fld_next;
        off_reg   <= off_next;
        base_reg  <= base_next;
        k_reg     <= k_next;
        iss_reg   <= iss_next;
        lane_reg  <= lane_next;
        acc_reg   <= acc_next;
        cnt_reg   <= cnt_next;
        fid_reg   <= fid_next;
        ob_reg    <= ob_next;
        ol_reg    <= ol_next;
        olast_reg <= olast_next;
    end

    always_comb
    begin
        logic [AW-1:0] rem;
        logic          fin;
        logic          lastc;
        state_next = state_reg;
        load       = 1'b0;
        fld_next   = fld_reg;
        off_next   = off_reg;
        base_next  = base_reg;
        k_next     = k_reg;
        iss_next   = iss_reg;
        rv_next    = 1'b0;
        lane_next  = lane_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !out_ready;
        fid_next   = fid_reg;
        ob_next    = ob_reg;
        ol_next    = ol_reg;
        olast_next = olast_reg;
        raddr      = base_reg + AW'(iss_reg);
        done       = 1'b0;
        rem        = fl_reg[fld_reg] - off_reg;
        fin        = (off_reg + AW'(k_reg)) == fl_reg[fld_reg];
        lastc      = (fld_reg == lsp_pkg::FID_TIME && fin) ||
                     (cnt_reg == CW'(lsp_pkg::MAX_RESULTS - 1));

        case (state_reg)
            lsp_pkg::EM_IDLE:
            begin
                if (go)
                begin
                    load       = 1'b1;
                    fld_next   = lsp_pkg::FID_SPOTTER;
                    off_next   = '0;
                    cnt_next   = '0;
                    state_next = lsp_pkg::EM_SETUP;
                end
            end

            lsp_pkg::EM_SETUP:
            begin
                k_next     = (int'(rem) > lsp_pkg::CHUNK_BYTES) ? 4'(lsp_pkg::CHUNK_BYTES)
                                                                : 4'(rem);
                base_next  = fs_reg[fld_reg] + off_reg;
                iss_next   = '0;
                acc_next   = '0;
                state_next = lsp_pkg::EM_READ;
            end

            lsp_pkg::EM_READ:
            begin
                if (iss_reg < k_reg)
                begin
                    rv_next   = 1'b1;
                    lane_next = iss_reg[2:0];
                    iss_next  = iss_reg + 4'd1;
                end
                if (rv_reg)
                begin
                    acc_next[lane_reg*8 +: 8] = rdata;
                end
                else if (iss_reg == k_reg)
                begin
                    state_next = lsp_pkg::EM_PUT;
                end
            end

            lsp_pkg::EM_PUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    fid_next   = fld_reg;
                    ob_next    = acc_reg;
                    ol_next    = k_reg;
                    olast_next = lastc;
                    cnt_next   = cnt_reg + CW'(1);
                    if (lastc)
                    begin
                        done       = 1'b1;
                        state_next = lsp_pkg::EM_IDLE;
                    end
                    else if (fin)
                    begin
                        fld_next   = fld_reg + 3'd1;
                        off_next   = '0;
                        state_next = lsp_pkg::EM_SETUP;
                    end
                    else
                    begin
                        off_next   = off_reg + AW'(k_reg);
                        state_next = lsp_pkg::EM_SETUP;
                    end
                end
            end

            default:
            begin
                state_next = lsp_pkg::EM_IDLE;
            end
        endcase
    end

    assign out_valid    = ov_reg;
    assign field_id     = fid_reg;
    assign chunk_bytes  = ob_reg;
    assign chunk_len    = ol_reg;
    assign last_of_spot = olast_reg;

endmodule

>>> rtl/core/spot_line_field_parser.sv
// ----------------------------------------------------------------------------
// Spot line field parser
// Collects text lines and splits cluster spot lines into tagged field chunks.
// ----------------------------------------------------------------------------
// Received bytes are written into a line store one transfer per cycle, so text
// streams in at a rate of one byte a cycle while a line is collected. A newline
// starts the scan of the stored line: one read of the final byte, then one pass
// over the line at one byte a cycle through the store's read port, the SC_FIN
// and SC_CALC bookkeeping states and, when a time stamp is present, a backward
// trim of the comment, one gap byte at a time. For a line that is a spot, the
// fields are then read back once more, one byte a cycle, to form chunks of up
// to eight bytes. No bytes are taken during scan and emission, which share the
// single read port of the line store. The result sits in an output register,
// so the next line may be taken while the last chunk still waits for its
// transfer. The store needs no clearing after reset: only bytes of the current
// line are ever read.
module spot_line_field_parser #(
    parameter int LINE_BYTES    = lsp_pkg::LINE_BYTES_DEF,
    parameter int SPOTTER_BYTES = lsp_pkg::SPOTTER_BYTES_DEF,
    parameter int FREQ_BYTES    = lsp_pkg::FREQ_BYTES_DEF,
    parameter int CALL_BYTES    = lsp_pkg::CALL_BYTES_DEF,
    parameter int COMMENT_BYTES = lsp_pkg::COMMENT_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  field_id,
    output logic [63:0] chunk_bytes,
    output logic [3:0]  chunk_len,
    output logic        last_of_spot
);

    localparam int AW = $clog2(LINE_BYTES);

    lsp_pkg::top_state_t state_reg, state_next;
    logic [AW-1:0]       line_len_reg, line_len_next;
    logic                accept;
    logic                is_nl;
    logic                we;
    logic [AW-1:0]       raddr;
    logic [AW-1:0]       scan_raddr;
    logic [AW-1:0]       emit_raddr;
    logic [7:0]          rdata;
    lsp_pkg::scan_stat_t scan_stat;
    logic                emit_go;
    logic                emit_done;
    logic [AW-1:0]       fs [lsp_pkg::NUM_FIELDS];
    logic [AW-1:0]       fl [lsp_pkg::NUM_FIELDS];

    assign in_ready = (state_reg == lsp_pkg::TP_COLLECT);
    assign accept   = in_valid && in_ready;
    assign is_nl    = (rx_byte == lsp_pkg::CH_NL);
    // A byte that would overflow the line is dropped and the line emptied.
    assign we       = accept && !is_nl && (line_len_reg < AW'(LINE_BYTES - 1));
    assign emit_go  = (state_reg == lsp_pkg::TP_SCAN) && scan_stat.done && scan_stat.spot;
    assign raddr    = (state_reg == lsp_pkg::TP_EMIT) ? emit_raddr : scan_raddr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lsp_pkg::TP_COLLECT;
            line_len_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            line_len_reg <= line_len_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        line_len_next = line_len_reg;
        if (accept)
        begin
            line_len_next = we ? line_len_reg + AW'(1) : '0;
        end
        case (state_reg)
            lsp_pkg::TP_COLLECT:
            begin
                if (accept && is_nl)
                begin
                    state_next = lsp_pkg::TP_SCAN;
                end
            end
            lsp_pkg::TP_SCAN:
            begin
                if (scan_stat.done)
                begin
                    state_next = scan_stat.spot ? lsp_pkg::TP_EMIT : lsp_pkg::TP_COLLECT;
                end
            end
            lsp_pkg::TP_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = lsp_pkg::TP_COLLECT;
                end
            end
            default:
            begin
                state_next = lsp_pkg::TP_COLLECT;
            end
        endcase
    end

    lsp_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_line_store (
        .clk   (clk),
        .we    (we),
        .waddr (line_len_reg),
        .wdata (rx_byte),
        .raddr (raddr),
        .rdata (rdata)
    );

    lsp_scan #(
        .LINE_BYTES    (LINE_BYTES),
        .SPOTTER_BYTES (SPOTTER_BYTES),
        .FREQ_BYTES    (FREQ_BYTES),
        .CALL_BYTES    (CALL_BYTES),
        .COMMENT_BYTES (COMMENT_BYTES)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && is_nl),
        .len   (line_len_reg),
        .raddr (scan_raddr),
        .rdata (rdata),
        .stat  (scan_stat),
        .fs    (fs),
        .fl    (fl)
    );

    lsp_emit #(
        .LINE_BYTES (LINE_BYTES)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (emit_go),
        .fs           (fs),
        .fl           (fl),
        .raddr        (emit_raddr),
        .rdata        (rdata),
        .done         (emit_done),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .field_id     (field_id),
        .chunk_bytes  (chunk_bytes),
        .chunk_len    (chunk_len),
        .last_of_spot (last_of_spot)
    );

    // A newline always hands the line over to the scanner.
    a_nl_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_nl |=> state_reg == lsp_pkg::TP_SCAN)
        else $error("newline did not start a scan");

    // The line never holds more than LINE_BYTES-1 bytes.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_len_reg <= AW'(LINE_BYTES - 1))
        else $error("line length beyond bound");

    // A spot found by the scanner moves control to the emitter.
    a_go_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> state_reg == lsp_pkg::TP_EMIT)
        else $error("spot not handed to emitter");

    // Chunks never carry more than eight bytes and name no field beyond the time field.
    a_chunk_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> chunk_len <= 4'd8 && field_id <= lsp_pkg::FID_TIME)
        else $error("malformed chunk");

endmodule

>>> bench/tb_spot_line_field_parser.sv
// ----------------------------------------------------------------------------
// Spot line field parser testbench
// Drives text lines into the parser and checks every field chunk it sends.
// ----------------------------------------------------------------------------
// Bytes go in through the input channel. A line model built into the
// scoreboard collects the same bytes and, at each newline, works out the
// field chunks that the block should send. Each result transfer is compared,
// field by field, with the oldest chunk still waiting. Directed lines cover
// the special cases: overflow, lines that are not spots, a missing time,
// truncated fields and empty fields. Random stimulus is mostly well-formed
// spot lines with random content, and the rest is noise and broken lines.
// ----------------------------------------------------------------------------
module tb_spot_line_field_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LB  = lsp_pkg::LINE_BYTES_DEF;
    localparam int SPB = lsp_pkg::SPOTTER_BYTES_DEF;
    localparam int FRB = lsp_pkg::FREQ_BYTES_DEF;
    localparam int CAB = lsp_pkg::CALL_BYTES_DEF;
    localparam int CMB = lsp_pkg::COMMENT_BYTES_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_ITEMS = 410;

    typedef struct packed {
        logic [2:0]  fid;
        logic [63:0] bytes;
        logic [3:0]  len;
        logic        last;
    } chunk_t;

    int error_count = 0;

    // A mismatch prints one line and is counted.
    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // The scoreboard holds its own copy of the line buffer and the queue of
    // chunks that are still to come out of the block.
    class spot_scoreboard;
        logic [7:0] line_buf [LB];
        int unsigned line_len;
        chunk_t pending_chunks [$];
        int chunk_count;

        function new();
            line_len = 0;
            foreach (line_buf[i]) line_buf[i] = 8'h00;
        endfunction

        function bit gap(input logic [7:0] c);
            return c == lsp_pkg::CH_SPACE || c == lsp_pkg::CH_TAB;
        endfunction

        function int unsigned clip(input int unsigned n, input int unsigned size);
            return n >= size ? size - 1 : n;
        endfunction

        function void add_field(input logic [2:0] fid, input int unsigned start,
                                input int unsigned len);
            int unsigned off;
            int unsigned k;
            chunk_t c;
            off = 0;
            do
            begin
                if (chunk_count >= lsp_pkg::MAX_RESULTS) return;
                k = len - off;
                if (k > 8) k = 8;
                c = '0;
                c.fid = fid;
                c.len = k[3:0];
                for (int i = 0; i < k; i++)
                    if (start + off + i < LB)
                        c.bytes[8*i +: 8] = line_buf[start + off + i];
                pending_chunks.push_back(c);
                chunk_count++;
                off += k;
            end
            while (off < len);
        endfunction

        function void split_line();
            int unsigned stop, colon, p, e, rest, clen, tm;
            int unsigned sp_n, fr_s, fr_n, ca_s, ca_n, cm_n;
            logic [7:0] c;
            stop = line_len;
            tm = 0;
            chunk_count = 0;
            if (stop > 0 && line_buf[stop-1] == lsp_pkg::CH_CR) stop--;
            for (int i = 0; i < stop; i++)
                if (line_buf[i] == lsp_pkg::CH_NUL)
                begin
                    stop = i;
                    break;
                end
            if (stop < lsp_pkg::PREFIX_LEN) return;
            for (int i = 0; i < lsp_pkg::PREFIX_LEN; i++)
                if (line_buf[i] != lsp_pkg::prefix_char(i[2:0])) return;
            colon = stop;
            for (int i = lsp_pkg::PREFIX_LEN; i < stop; i++)
                if (line_buf[i] == lsp_pkg::CH_COLON)
                begin
                    colon = i;
                    break;
                end
            if (colon == stop) return;
            sp_n = clip(colon - lsp_pkg::PREFIX_LEN, SPB);
            p = colon + 1;
            while (p < stop && gap(line_buf[p])) p++;
            e = p;
            while (e < stop && !gap(line_buf[e])) e++;
            fr_s = p;
            fr_n = clip(e - p, FRB);
            p = e;
            while (p < stop && gap(line_buf[p])) p++;
            e = p;
            while (e < stop && !gap(line_buf[e])) e++;
            ca_s = p;
            ca_n = clip(e - p, CAB);
            p = e;
            while (p < stop && gap(line_buf[p])) p++;
            rest = stop - p;
            while (rest > 0)
            begin
                c = line_buf[p + rest - 1];
                if (c == lsp_pkg::CH_SPACE || c == lsp_pkg::CH_CR ||
                    c == lsp_pkg::CH_NL || c == lsp_pkg::CH_TAB) rest--;
                else break;
            end
            if (rest >= lsp_pkg::TIME_LEN && line_buf[p + rest - 1] == lsp_pkg::CH_Z)
            begin
                tm = lsp_pkg::TIME_LEN;
                clen = rest - lsp_pkg::TIME_LEN;
                while (clen > 0 && gap(line_buf[p + clen - 1])) clen--;
            end
            else
            begin
                clen = rest;
            end
            cm_n = clip(clen, CMB);
            add_field(lsp_pkg::FID_SPOTTER, lsp_pkg::PREFIX_LEN, sp_n);
            add_field(lsp_pkg::FID_FREQ, fr_s, fr_n);
            add_field(lsp_pkg::FID_CALL, ca_s, ca_n);
            add_field(lsp_pkg::FID_COMMENT, p, cm_n);
            add_field(lsp_pkg::FID_TIME, p + rest - tm, tm);
            if (chunk_count > 0) pending_chunks[$].last = 1'b1;
        endfunction

        function void note_byte(input logic [7:0] b);
            if (b == lsp_pkg::CH_NL)
            begin
                split_line();
                line_len = 0;
            end
            else if (line_len < LB - 1)
            begin
                line_buf[line_len] = b;
                line_len++;
            end
            else
            begin
                line_len = 0;
            end
        endfunction

        task check_chunk(input chunk_t got);
            chunk_t want;
            if (pending_chunks.size() == 0)
            begin
                report($sformatf("unexpected chunk fid=%0d len=%0d", got.fid, got.len));
                return;
            end
            want = pending_chunks.pop_front();
            if (got.fid != want.fid)
                report($sformatf("field_id %0d, want %0d", got.fid, want.fid));
            if (got.bytes != want.bytes)
                report($sformatf("chunk_bytes %h, want %h", got.bytes, want.bytes));
            if (got.len != want.len)
                report($sformatf("chunk_len %0d, want %0d", got.len, want.len));
            if (got.last != want.last)
                report($sformatf("last_of_spot %0b, want %0b", got.last, want.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  field_id;
    logic [63:0] chunk_bytes;
    logic [3:0]  chunk_len;
    logic        last_of_spot;

    spot_scoreboard spot_sb = new();
    bit  calm = 1'b0;       // no idling on either side while set
    int  idle_cycles = 0;
    int  byte_count = 0;
    byte unsigned text_q [$];

    spot_line_field_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .field_id     (field_id),
        .chunk_bytes  (chunk_bytes),
        .chunk_len    (chunk_len),
        .last_of_spot (last_of_spot)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Transfers are seen at the rising edge; the watchdog counts quiet cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                spot_sb.check_chunk({field_id, chunk_bytes, chunk_len, last_of_spot});
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_spot_line_field_parser: errors");
                $finish;
            end
        end
    end

    // The receiver stalls in about 12 percent of cycles unless calm is set.
    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 12);
    end

    // Sends one byte and waits for its transfer; the byte is noted on transfer.
    // Valid stays high into the next byte unless the sender idles.
    task automatic send_byte(input byte unsigned b);
        while (!calm && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        spot_sb.note_byte(b);
        byte_count++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic string rand_word(input int n);
        string s;
        byte unsigned c;
        s = "";
        for (int i = 0; i < n; i++)
        begin
            c = 8'($urandom_range(33, 126));
            if (c == lsp_pkg::CH_COLON && $urandom_range(3) != 0) c = "A";
            s = {s, string'(c)};
        end
        return s;
    endfunction

    function automatic string rand_gap();
        return ($urandom_range(3) == 0) ? "\t " : (($urandom_range(2) == 0) ? "  " : " ");
    endfunction

    // A well-formed spot line with random field sizes and content.
    function automatic string rand_spot();
        string s;
        s = {"DX de ", rand_word($urandom_range(0, 20)), ":", rand_gap(),
             rand_word($urandom_range(0, 18)), rand_gap(), rand_word($urandom_range(0, 18)),
             rand_gap()};
        for (int i = $urandom_range(0, 4); i > 0; i--)
            s = {s, rand_word($urandom_range(1, 20)), rand_gap()};
        if ($urandom_range(3) != 0)
            s = {s, $sformatf("%04dZ", $urandom_range(0, 2359))};
        if ($urandom_range(3) == 0) s = {s, "  "};
        if ($urandom_range(1) == 0) s = {s, "\r"};
        return {s, "\n"};
    endfunction

    initial
    begin
        string s;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed lines.
        send_text("DX de AB1CD:   14025.0  K1XYZ   CQ test   1234Z\r\n");
        send_text("DX de X:1 Y\n");                        // missing time, short
        send_text("DX de :\n");                            // all fields empty
        send_text("DX de NOCOLON here\n");                 // no colon: no spot
        send_text("DX dx A: B C\n");                       // wrong prefix
        send_text("DX d\n");                               // too short
        send_text("\n");
        send_text("DX de A");                              // NUL cuts the line
        send_byte(lsp_pkg::CH_NUL);
        send_text("B: 1 2\n");
        send_text("DX de LONGSPOTTERCALLSIGN123:LONGFREQUENCY1234567 ");
        send_text("VERYLONGDXCALLSIGN ");
        send_text({rand_word(40), " ", rand_word(40), " 0000Z\n"}); // long fields
        send_text("DX de A: 1 2 note\tZZZZZ\t\n");
        send_text("DX de A: 1 2 Z\r\r\n");
        // Overflow: LB + 3 bytes without a newline, then the text of a spot line.
        // The whole stretch runs without idling on either side.
        calm = 1'b1;
        for (int i = 0; i < LB + 3; i++) send_byte(8'($urandom_range(11, 255)));
        send_text("DX de B: 7 8 x 1200Z\n");
        calm = 1'b0;
        send_byte(8'hFF);
        send_byte(lsp_pkg::CH_NUL);
        send_byte(lsp_pkg::CH_NL);

        // Random part: mostly spots, some noise and broken lines.
        while (byte_count < LB + NUM_ITEMS)
        begin
            case ($urandom_range(9))
                0: s = {rand_word($urandom_range(0, 30)), "\n"};
                1:
                begin
                    s = rand_spot();
                    s[$urandom_range(0, s.len()-2)] = 8'($urandom_range(0, 255));
                end
                default: s = rand_spot();
            endcase
            for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
            while (text_q.size() > 0) send_byte(text_q.pop_front());
        end
        in_valid <= 1'b0;

        while (spot_sb.pending_chunks.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0 && spot_sb.pending_chunks.size() == 0)
            $display("tb_spot_line_field_parser: clean");
        else
            $display("tb_spot_line_field_parser: errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lsp_pkg.sv
rtl/core/lsp_ram.sv
rtl/core/lsp_scan.sv
rtl/core/lsp_emit.sv
rtl/core/spot_line_field_parser.sv
bench/tb_spot_line_field_parser.sv
